@@ rtl/core/sab_pkg.sv @@
// Shared constants and the divide-by-255 helper for the scaled alpha blit core.
package sab_pkg;

    localparam int unsigned SRC_W = 256;
    localparam int unsigned SRC_H = 256;

    localparam int unsigned SX_W   = (SRC_W > 1) ? $clog2(SRC_W) : 1;
    localparam int unsigned SY_W   = (SRC_H > 1) ? $clog2(SRC_H) : 1;
    localparam int unsigned DEPTH  = SRC_W * SRC_H;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int unsigned POS_W  = 12;
    localparam int unsigned REG_W  = 13;
    localparam int unsigned NUM_W  = POS_W + REG_W;
    localparam int unsigned CRD_W  = NUM_W + 2;

    localparam logic [7:0] CH_MAX = 8'hFF;

    localparam logic [2:0] CFG_DEST_W   = 3'd0;
    localparam logic [2:0] CFG_DEST_H   = 3'd1;
    localparam logic [2:0] CFG_SRC_L    = 3'd2;
    localparam logic [2:0] CFG_SRC_T    = 3'd3;
    localparam logic [2:0] CFG_SRC_W    = 3'd4;
    localparam logic [2:0] CFG_SRC_H    = 3'd5;
    localparam logic [2:0] CFG_FADE     = 3'd6;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    // exact x/255 for x <= 65025
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

@@ rtl/core/scaled_alpha_blit_top.sv @@
// Scaled alpha blit core: pipelined nearest-neighbor scaling and source-over blend.
//
// Input channel (i_valid / o_stall): one word per cycle while o_stall is low,
// either a load (i_mode = 0) that writes a source pixel into the 256x256
// on-chip store, or a draw (i_mode = 1) carrying an offset in the destination
// rectangle and the current destination pixel. Loads give no result; each draw
// gives one result on the output channel (o_valid / i_stall): the pixel to
// write back and a flag that is set when the pixel was blended.
// Configuration: i_cfg_valid / o_cfg_ready with register index and data; ready
// is always high. Write registers only while the pipeline is empty.
// Throughput: one word per cycle while the output is not stalled. Stages in
// order: one product stage, the two 25-stage dividers for the scaling
// coordinates, one address stage, the store read, three blend stages and the
// output register.
// Loads and draws travel the same pipeline, so the store is written and read in
// word order.
// Reset clears all valid bits and the registers to their defaults; the store
// contents are undefined until loaded.
// When i_stall is high with a result waiting, the whole pipeline holds and
// o_stall rises; nothing is lost or repeated.
module scaled_alpha_blit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,
    input  logic [31:0] i_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_pixel,
    output logic        o_changed,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    localparam int unsigned NW = sab_pkg::NUM_W;
    localparam int unsigned RW = sab_pkg::REG_W;
    localparam int unsigned AW = sab_pkg::ADDR_W;
    localparam int unsigned CW = sab_pkg::CRD_W;

    typedef struct packed {
        logic          valid;
        logic          draw;
        logic          empty;
        logic [11:0]   px;
        logic [11:0]   py;
        logic [31:0]   pix;
        logic [NW-1:0] num_x;
        logic [RW-1:0] rem_x;
        logic [NW-1:0] q_x;
        logic [NW-1:0] num_y;
        logic [RW-1:0] rem_y;
        logic [NW-1:0] q_y;
    } t_dv;

    typedef struct packed {
        logic          valid;
        logic          draw;
        logic          we;
        logic          chg;
        logic [AW-1:0] addr;
        logic [31:0]   pix;
    } t_ad;

    typedef struct packed {
        logic        valid;
        logic        draw;
        logic        chg;
        logic [31:0] dst;
    } t_mm;

    typedef struct packed {
        logic        valid;
        logic        draw;
        logic        chg;
        logic [31:0] dst;
        logic [23:0] src;
        logic [15:0] pa;
    } t_b1;

    typedef struct packed {
        logic        valid;
        logic        draw;
        logic        chg;
        logic [31:0] dst;
        logic [23:0] src;
        logic [7:0]  fa;
        logic [7:0]  inv;
    } t_b2;

    typedef struct packed {
        logic        valid;
        logic        draw;
        logic        chg;
        logic [31:0] dst;
        logic [7:0]  fa;
        logic [15:0] pa;
        logic [15:0] pr;
        logic [15:0] pg;
        logic [15:0] pb;
    } t_b3;

    logic [RW-1:0] r_dest_w, r_dest_h, r_src_l, r_src_t, r_src_w, r_src_h;
    logic [7:0]    r_fade;

    logic [31:0]   r_mem [0:sab_pkg::DEPTH-1];
    logic [31:0]   r_rd;

    t_dv r_dv [0:NW];
    t_dv n_dv [0:NW];
    t_ad r_ad, n_ad;
    t_mm r_mm;
    t_b1 r_b1, n_b1;
    t_b2 r_b2, n_b2;
    t_b3 r_b3, n_b3;

    logic          r_o_valid;
    logic [31:0]   r_o_pixel;
    logic          r_o_changed;
    logic          adv;

    assign adv         = !r_o_valid || !i_stall;
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_out_pixel = r_o_pixel;
    assign o_changed   = r_o_changed;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_w <= RW'(1);
            r_dest_h <= RW'(1);
            r_src_l  <= '0;
            r_src_t  <= '0;
            r_src_w  <= RW'(1);
            r_src_h  <= RW'(1);
            r_fade   <= sab_pkg::CH_MAX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sab_pkg::CFG_DEST_W: r_dest_w <= i_cfg_data;
                sab_pkg::CFG_DEST_H: r_dest_h <= i_cfg_data;
                sab_pkg::CFG_SRC_L:  r_src_l  <= i_cfg_data;
                sab_pkg::CFG_SRC_T:  r_src_t  <= i_cfg_data;
                sab_pkg::CFG_SRC_W:  r_src_w  <= i_cfg_data;
                sab_pkg::CFG_SRC_H:  r_src_h  <= i_cfg_data;
                sab_pkg::CFG_FADE:   r_fade   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // entry: scale products, then one quotient bit per stage
    always_comb begin
        logic [RW:0] sh_x, sh_y;
        n_dv[0]       = '0;
        n_dv[0].valid = i_valid;
        n_dv[0].draw  = (i_mode == sab_pkg::MODE_DRAW);
        n_dv[0].empty = (r_dest_w == '0) || (r_dest_h == '0) ||
                        (r_src_w == '0) || (r_src_h == '0);
        n_dv[0].px    = i_pos_x;
        n_dv[0].py    = i_pos_y;
        n_dv[0].pix   = i_pixel;
        n_dv[0].num_x = NW'(i_pos_x) * NW'(r_src_w);
        n_dv[0].num_y = NW'(i_pos_y) * NW'(r_src_h);
        for (int k = 1; k <= NW; k++) begin
            n_dv[k] = r_dv[k-1];
            sh_x = {r_dv[k-1].rem_x, r_dv[k-1].num_x[NW-1]};
            sh_y = {r_dv[k-1].rem_y, r_dv[k-1].num_y[NW-1]};
            n_dv[k].num_x = {r_dv[k-1].num_x[NW-2:0], 1'b0};
            n_dv[k].num_y = {r_dv[k-1].num_y[NW-2:0], 1'b0};
            if (sh_x >= {1'b0, r_dest_w}) begin
                n_dv[k].rem_x = RW'(sh_x - {1'b0, r_dest_w});
                n_dv[k].q_x   = {r_dv[k-1].q_x[NW-2:0], 1'b1};
            end else begin
                n_dv[k].rem_x = sh_x[RW-1:0];
                n_dv[k].q_x   = {r_dv[k-1].q_x[NW-2:0], 1'b0};
            end
            if (sh_y >= {1'b0, r_dest_h}) begin
                n_dv[k].rem_y = RW'(sh_y - {1'b0, r_dest_h});
                n_dv[k].q_y   = {r_dv[k-1].q_y[NW-2:0], 1'b1};
            end else begin
                n_dv[k].rem_y = sh_y[RW-1:0];
                n_dv[k].q_y   = {r_dv[k-1].q_y[NW-2:0], 1'b0};
            end
        end
    end

    for (genvar g = 0; g <= NW; g++) begin : g_dv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g].valid <= 1'b0;
            end else if (adv) begin
                r_dv[g] <= n_dv[g];
            end
        end
    end

    // source coordinate, bounds and store address
    always_comb begin
        logic signed [CW-1:0] sx, sy;
        logic                 inb;
        t_dv                  d;
        d  = r_dv[NW];
        sx = $signed({{(CW-RW){r_src_l[RW-1]}}, r_src_l}) + $signed({2'b00, d.q_x});
        sy = $signed({{(CW-RW){r_src_t[RW-1]}}, r_src_t}) + $signed({2'b00, d.q_y});
        inb = !sx[CW-1] && !sy[CW-1] &&
              (sx < $signed(CW'(sab_pkg::SRC_W))) && (sy < $signed(CW'(sab_pkg::SRC_H)));
        n_ad       = '0;
        n_ad.valid = d.valid;
        n_ad.draw  = d.draw;
        n_ad.pix   = d.pix;
        if (d.draw) begin
            n_ad.chg  = inb && !d.empty;
            n_ad.addr = AW'(AW'(sy[sab_pkg::SY_W-1:0]) * AW'(sab_pkg::SRC_W))
                        + AW'(sx[sab_pkg::SX_W-1:0]);
        end else begin
            n_ad.we   = d.valid && (32'(d.px) < sab_pkg::SRC_W)
                                && (32'(d.py) < sab_pkg::SRC_H);
            n_ad.addr = AW'(AW'(d.py[sab_pkg::SY_W-1:0]) * AW'(sab_pkg::SRC_W))
                        + AW'(d.px[sab_pkg::SX_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ad.valid <= 1'b0;
        end else if (adv) begin
            r_ad <= n_ad;
        end
    end

    // source store
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_ad.we) begin
                r_mem[r_ad.addr] <= r_ad.pix;
            end
            r_rd <= r_mem[r_ad.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm.valid <= 1'b0;
        end else if (adv) begin
            r_mm.valid <= r_ad.valid;
            r_mm.draw  <= r_ad.draw;
            r_mm.chg   <= r_ad.chg && r_ad.draw;
            r_mm.dst   <= r_ad.pix;
        end
    end

    // blend: faded alpha, then channel products, then /255
    always_comb begin
        n_b1       = '0;
        n_b1.valid = r_mm.valid;
        n_b1.draw  = r_mm.draw;
        n_b1.chg   = r_mm.chg;
        n_b1.dst   = r_mm.dst;
        n_b1.src   = r_rd[23:0];
        n_b1.pa    = 16'(r_rd[31:24]) * 16'(r_fade);

        n_b2       = '0;
        n_b2.valid = r_b1.valid;
        n_b2.draw  = r_b1.draw;
        n_b2.chg   = r_b1.chg;
        n_b2.dst   = r_b1.dst;
        n_b2.src   = r_b1.src;
        n_b2.fa    = sab_pkg::div255(r_b1.pa);
        n_b2.inv   = sab_pkg::CH_MAX - sab_pkg::div255(r_b1.pa);

        n_b3       = '0;
        n_b3.valid = r_b2.valid;
        n_b3.draw  = r_b2.draw;
        n_b3.chg   = r_b2.chg;
        n_b3.dst   = r_b2.dst;
        n_b3.fa    = r_b2.fa;
        n_b3.pa    = 16'(r_b2.dst[31:24]) * 16'(r_b2.inv);
        n_b3.pr    = 16'(r_b2.src[23:16]) * 16'(r_b2.fa) + 16'(r_b2.dst[23:16]) * 16'(r_b2.inv);
        n_b3.pg    = 16'(r_b2.src[15:8])  * 16'(r_b2.fa) + 16'(r_b2.dst[15:8])  * 16'(r_b2.inv);
        n_b3.pb    = 16'(r_b2.src[7:0])   * 16'(r_b2.fa) + 16'(r_b2.dst[7:0])   * 16'(r_b2.inv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1.valid  <= 1'b0;
            r_b2.valid  <= 1'b0;
            r_b3.valid  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else if (adv) begin
            r_b1 <= n_b1;
            r_b2 <= n_b2;
            r_b3 <= n_b3;
            r_o_valid   <= r_b3.valid && r_b3.draw;
            r_o_changed <= r_b3.chg;
            if (r_b3.chg) begin
                r_o_pixel <= {r_b3.fa + sab_pkg::div255(r_b3.pa),
                              sab_pkg::div255(r_b3.pr),
                              sab_pkg::div255(r_b3.pg),
                              sab_pkg::div255(r_b3.pb)};
            end else begin
                r_o_pixel <= r_b3.dst;
            end
        end
    end

    // a held result freezes the address and blend stages behind it
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && i_stall |=> $stable(r_b3.valid) && $stable(r_b3.dst) && $stable(r_ad))
        else $error("pipeline moved while output stalled");

    // a load never carries a blend flag past the store
    a_load_nochg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mm.valid && !r_mm.draw |-> !r_mm.chg)
        else $error("load word flagged as changed");

    // an unchanged result passes the destination word through
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_b3.valid && r_b3.draw && !r_b3.chg |=> o_valid && o_out_pixel == $past(r_b3.dst))
        else $error("pass-through pixel altered");

endmodule
